// ----- sv/kssc_pkg.sv -----
// Package for the kinematic step block: opcodes, controller commands,
// controller/datapath struct types and fixed field widths. No dependencies.
package kssc_pkg;

    localparam int DT_WIDTH        = 16;
    localparam int DT_FRAC         = 8;
    localparam int MAX_SPEED_WIDTH = 31;
    localparam int ADDR_WIDTH      = 3;
    localparam int DATA_WIDTH      = 32;

    typedef enum logic [ADDR_WIDTH-1:0] {
        REG_MAX_SPEED = 3'd0
    } reg_addr_t;

    typedef enum logic [1:0] {
        OP_LOAD_POS = 2'd0,
        OP_LOAD_VEL = 2'd1,
        OP_LOAD_ACC = 2'd2,
        OP_STEP     = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        CMD_NONE  = 4'd0,
        CMD_LOAD  = 4'd1,
        CMD_PMUL  = 4'd2,
        CMD_PADD  = 4'd3,
        CMD_VMUL  = 4'd4,
        CMD_VADD  = 4'd5,
        CMD_SMUL  = 4'd6,
        CMD_SADD  = 4'd7,
        CMD_RINIT = 4'd8,
        CMD_RSTEP = 4'd9,
        CMD_FLAG  = 4'd10,
        CMD_CMUL  = 4'd11,
        CMD_DINIT = 4'd12,
        CMD_DSTEP = 4'd13,
        CMD_DWB   = 4'd14
    } cmd_code_t;

    typedef struct packed {
        cmd_code_t  code;
        logic [1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic clamp_needed;
    } status_t;

endpackage

// ----- sv/kssc_req_if.sv -----
// Input channel of the kinematic step block: valid/ready plus one item.
// Depends on nothing.
interface kssc_req_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    op;
    logic signed [VALUE_WIDTH-1:0] value_x;
    logic signed [VALUE_WIDTH-1:0] value_y;
    logic signed [VALUE_WIDTH-1:0] value_z;
    logic [15:0]                   dt;

    modport source (output valid, op, value_x, value_y, value_z, dt, input ready);
    modport sink   (input valid, op, value_x, value_y, value_z, dt, output ready);
endinterface

// ----- sv/kssc_rsp_if.sv -----
// Output channel of the kinematic step block: valid/ready plus the state item.
// Depends on nothing.
interface kssc_rsp_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] pos_x;
    logic signed [VALUE_WIDTH-1:0] pos_y;
    logic signed [VALUE_WIDTH-1:0] pos_z;
    logic signed [VALUE_WIDTH-1:0] vel_x;
    logic signed [VALUE_WIDTH-1:0] vel_y;
    logic signed [VALUE_WIDTH-1:0] vel_z;
    logic                          speed_clamped;

    modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                    speed_clamped, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                    speed_clamped, output ready);
endinterface

// ----- sv/kinematic_step_speed_clamp.sv -----
// Top level of the kinematic step block: APB register, channels, controller
// and datapath. Depends on kssc_pkg, kssc_req_if, kssc_rsp_if, kssc_ctrl, kssc_dp.
//
// Usage:
//   req carries one item: op selects load position, load velocity, load
//   acceleration or a kinematic step with time step dt (unsigned Q8.8).
//   rsp returns one item per request: position, velocity and speed_clamped.
//   max_speed (unsigned, 31 bits) sits at APB byte address 0; write it only
//   while no item is in flight. Reads return the current limit.
// Timing:
//   One item at a time. req.ready is high only while the block is idle.
//   A load item is answered in the cycle after acceptance. A step item runs
//   the Euler multiply/add, the sum of squares, the bit-per-cycle square
//   root and the limit check. A clamped step adds the three restoring
//   divisions. The multiplier is shared, and the root and divide produce
//   one bit per cycle.
// Reset: vectors clear to zero, max_speed to its maximum, channels idle.
// Stall: the result holds on rsp until taken; no new item enters meanwhile.
module kinematic_step_speed_clamp #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [kssc_pkg::ADDR_WIDTH-1:0]   paddr,
    input  logic [kssc_pkg::DATA_WIDTH-1:0]   pwdata,
    output logic [kssc_pkg::DATA_WIDTH-1:0]   prdata,
    output logic                              pready,
    kssc_req_if.sink                          req,
    kssc_rsp_if.source                        rsp
);
    localparam int MSW = kssc_pkg::MAX_SPEED_WIDTH;

    logic [MSW-1:0] max_speed_reg;
    logic           reg_hit;
    kssc_pkg::cmd_t    cmd;
    kssc_pkg::status_t status;
    kssc_pkg::op_t     in_op;
    logic signed [VALUE_WIDTH-1:0] in_val [3];
    logic signed [VALUE_WIDTH-1:0] pos [3];
    logic signed [VALUE_WIDTH-1:0] vel [3];
    logic clamped;

    // config port: zero wait states
    assign pready  = 1'b1;
    assign reg_hit = paddr == kssc_pkg::REG_MAX_SPEED;
    assign prdata  = reg_hit ? kssc_pkg::DATA_WIDTH'(max_speed_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_speed_reg <= {MSW{1'b1}};
        else if (psel && penable && pwrite && reg_hit)
            max_speed_reg <= pwdata[MSW-1:0];
    end

    assign in_op     = kssc_pkg::op_t'(req.op);
    assign in_val[0] = req.value_x;
    assign in_val[1] = req.value_y;
    assign in_val[2] = req.value_z;

    kssc_ctrl #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_op     (in_op),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .status    (status)
    );

    kssc_dp #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_op     (in_op),
        .in_val    (in_val),
        .in_dt     (req.dt),
        .max_speed (max_speed_reg),
        .pos       (pos),
        .vel       (vel),
        .clamped   (clamped)
    );

    // result stays on the state registers, which hold while rsp waits
    assign rsp.pos_x         = pos[0];
    assign rsp.pos_y         = pos[1];
    assign rsp.pos_z         = pos[2];
    assign rsp.vel_x         = vel[0];
    assign rsp.vel_y         = vel[1];
    assign rsp.vel_z         = vel[2];
    assign rsp.speed_clamped = clamped;
endmodule

// ----- sv/kssc_ctrl.sv -----
// Sequencer of the kinematic step block: walks Euler, norm, root and clamp.
// Depends on kssc_pkg.
module kssc_ctrl #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  kssc_pkg::op_t     in_op,
    output logic              out_valid,
    input  logic              out_ready,
    output kssc_pkg::cmd_t    cmd,
    input  kssc_pkg::status_t status
);
    localparam int CW = $clog2(VALUE_WIDTH);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_PMUL  = 14'b00000000000010,
        S_PADD  = 14'b00000000000100,
        S_VMUL  = 14'b00000000001000,
        S_VADD  = 14'b00000000010000,
        S_SMUL  = 14'b00000000100000,
        S_SADD  = 14'b00000001000000,
        S_RINIT = 14'b00000010000000,
        S_RSTEP = 14'b00000100000000,
        S_CHECK = 14'b00001000000000,
        S_CMUL  = 14'b00010000000000,
        S_DINIT = 14'b00100000000000,
        S_DSTEP = 14'b01000000000000,
        S_OUT   = 14'b10000000000000
    } state_t;

    state_t          state_reg, state_next;
    logic [1:0]      idx_reg, idx_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            last_idx, last_cnt;

    assign last_idx  = idx_reg == 2'd2;
    assign last_cnt  = cnt_reg == CW'(VALUE_WIDTH - 1);
    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = state_reg == S_OUT;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        cmd.code   = kssc_pkg::CMD_NONE;
        cmd.idx    = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.code = kssc_pkg::CMD_LOAD;
                    idx_next = 2'd0;
                    state_next = (in_op == kssc_pkg::OP_STEP) ? S_PMUL : S_OUT;
                end
            end
            S_PMUL:
            begin
                cmd.code   = kssc_pkg::CMD_PMUL;
                state_next = S_PADD;
            end
            S_PADD:
            begin
                cmd.code   = kssc_pkg::CMD_PADD;
                idx_next   = last_idx ? 2'd0 : idx_reg + 2'd1;
                state_next = last_idx ? S_VMUL : S_PMUL;
            end
            S_VMUL:
            begin
                cmd.code   = kssc_pkg::CMD_VMUL;
                state_next = S_VADD;
            end
            S_VADD:
            begin
                cmd.code   = kssc_pkg::CMD_VADD;
                idx_next   = last_idx ? 2'd0 : idx_reg + 2'd1;
                state_next = last_idx ? S_SMUL : S_VMUL;
            end
            S_SMUL:
            begin
                cmd.code   = kssc_pkg::CMD_SMUL;
                state_next = S_SADD;
            end
            S_SADD:
            begin
                cmd.code   = kssc_pkg::CMD_SADD;
                idx_next   = last_idx ? 2'd0 : idx_reg + 2'd1;
                state_next = last_idx ? S_RINIT : S_SMUL;
            end
            S_RINIT:
            begin
                cmd.code   = kssc_pkg::CMD_RINIT;
                cnt_next   = '0;
                state_next = S_RSTEP;
            end
            S_RSTEP:
            begin
                cmd.code   = kssc_pkg::CMD_RSTEP;
                cnt_next   = cnt_reg + CW'(1);
                if (last_cnt)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.clamp_needed)
                begin
                    cmd.code   = kssc_pkg::CMD_FLAG;
                    idx_next   = 2'd0;
                    state_next = S_CMUL;
                end
                else
                    state_next = S_OUT;
            end
            S_CMUL:
            begin
                cmd.code   = kssc_pkg::CMD_CMUL;
                state_next = S_DINIT;
            end
            S_DINIT:
            begin
                cmd.code   = kssc_pkg::CMD_DINIT;
                cnt_next   = '0;
                state_next = S_DSTEP;
            end
            S_DSTEP:
            begin
                cmd.code = kssc_pkg::CMD_DSTEP;
                cnt_next = cnt_reg + CW'(1);
                if (last_cnt)
                begin
                    // quotient complete: write back on the way out
                    cmd.code   = kssc_pkg::CMD_DWB;
                    idx_next   = last_idx ? 2'd0 : idx_reg + 2'd1;
                    state_next = last_idx ? S_OUT : S_CMUL;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= 2'd0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
        end
    end
endmodule

// ----- sv/kssc_dp.sv -----
// Datapath of the kinematic step block: state vectors, shared multiplier,
// root and divide registers. Depends on kssc_pkg.
module kssc_dp #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kssc_pkg::cmd_t                cmd,
    output kssc_pkg::status_t             status,
    input  kssc_pkg::op_t                 in_op,
    input  logic signed [VALUE_WIDTH-1:0] in_val [3],
    input  logic [kssc_pkg::DT_WIDTH-1:0] in_dt,
    input  logic [kssc_pkg::MAX_SPEED_WIDTH-1:0] max_speed,
    output logic signed [VALUE_WIDTH-1:0] pos [3],
    output logic signed [VALUE_WIDTH-1:0] vel [3],
    output logic                          clamped
);
    localparam int W  = VALUE_WIDTH;
    localparam int MSW = kssc_pkg::MAX_SPEED_WIDTH;
    localparam int MB = (W > MSW) ? W : MSW;
    localparam int PW = W + MB;
    localparam int SW = 2 * W;
    localparam int EW = W + 10;

    logic signed [W-1:0] pos_reg [3];
    logic signed [W-1:0] vel_reg [3];
    logic signed [W-1:0] acc_reg [3];
    logic [kssc_pkg::DT_WIDTH-1:0] dt_reg;
    logic                clamped_reg;
    logic                neg_reg;
    logic [PW-1:0]       prod_reg;
    logic [SW-1:0]       sum_reg;
    logic [SW-1:0]       n_reg, root_reg, bit_reg;
    logic [W:0]          rem_reg;
    logic [W-1:0]        lo_reg;

    logic signed [W-1:0] src;
    logic [W-1:0]        src_mag;
    logic [MB-1:0]       mul_b;
    logic [PW-1:0]       mul_p;
    logic [PW-1:0]       prod_sh;
    logic [W+8:0]        eu_mag;
    logic signed [W-1:0] eu_dst;
    logic signed [EW-1:0] eu_ext, eu_tot;
    logic signed [W-1:0] eu_sat;
    logic [SW-1:0]       r_trial;
    logic [W-1:0]        speed;
    logic [W:0]          d_rem2;
    logic                d_ge;
    logic [PW-1:0]       div_hi;

    always_comb
    begin
        unique case (cmd.code)
            kssc_pkg::CMD_VMUL: src = acc_reg[cmd.idx];
            default:            src = vel_reg[cmd.idx];
        endcase
    end

    assign src_mag = src[W-1] ? W'(-src) : W'(src);

    always_comb
    begin
        unique case (cmd.code)
            kssc_pkg::CMD_SMUL: mul_b = MB'(src_mag);
            kssc_pkg::CMD_CMUL: mul_b = MB'(max_speed);
            default:            mul_b = MB'(dt_reg);
        endcase
    end

    assign mul_p = PW'(src_mag) * PW'(mul_b);

    // Euler update: truncate magnitude, apply sign, saturate to W bits
    assign prod_sh = prod_reg >> kssc_pkg::DT_FRAC;
    assign eu_mag  = prod_sh[W+8:0];
    assign eu_dst  = (cmd.code == kssc_pkg::CMD_PADD) ? pos_reg[cmd.idx] : vel_reg[cmd.idx];
    assign eu_ext  = EW'(eu_dst);
    assign eu_tot  = neg_reg ? eu_ext - $signed({1'b0, eu_mag})
                             : eu_ext + $signed({1'b0, eu_mag});

    always_comb
    begin
        if (eu_tot[EW-1:W-1] == '0 || eu_tot[EW-1:W-1] == '1)
            eu_sat = eu_tot[W-1:0];
        else
            eu_sat = eu_tot[EW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end

    assign r_trial = root_reg + bit_reg;
    assign speed   = root_reg[W-1:0];
    assign status.clamp_needed = MB'(speed) > MB'(max_speed);

    assign div_hi = prod_reg >> W;
    assign d_rem2 = {rem_reg[W-1:0], lo_reg[W-1]};
    assign d_ge   = d_rem2 >= {1'b0, speed};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
                acc_reg[i] <= '0;
            end
            clamped_reg <= 1'b0;
        end
        else
        begin
            unique case (cmd.code)
                kssc_pkg::CMD_LOAD:
                begin
                    clamped_reg <= 1'b0;
                    for (int i = 0; i < 3; i++)
                    begin
                        unique case (in_op)
                            kssc_pkg::OP_LOAD_POS: pos_reg[i] <= in_val[i];
                            kssc_pkg::OP_LOAD_VEL: vel_reg[i] <= in_val[i];
                            kssc_pkg::OP_LOAD_ACC: acc_reg[i] <= in_val[i];
                            default: ;
                        endcase
                    end
                end
                kssc_pkg::CMD_PADD: pos_reg[cmd.idx] <= eu_sat;
                kssc_pkg::CMD_VADD: vel_reg[cmd.idx] <= eu_sat;
                kssc_pkg::CMD_FLAG: clamped_reg <= 1'b1;
                kssc_pkg::CMD_DWB:
                    vel_reg[cmd.idx] <= neg_reg ? -$signed({lo_reg[W-2:0], d_ge})
                                                : $signed({lo_reg[W-2:0], d_ge});
                default: ;
            endcase
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        unique case (cmd.code)
            kssc_pkg::CMD_LOAD:
            begin
                dt_reg  <= in_dt;
                sum_reg <= '0;
            end
            kssc_pkg::CMD_PMUL, kssc_pkg::CMD_VMUL, kssc_pkg::CMD_SMUL,
            kssc_pkg::CMD_CMUL:
            begin
                prod_reg <= mul_p;
                neg_reg  <= src[W-1];
            end
            kssc_pkg::CMD_SADD: sum_reg <= sum_reg + prod_reg[SW-1:0];
            kssc_pkg::CMD_RINIT:
            begin
                n_reg    <= sum_reg;
                root_reg <= '0;
                bit_reg  <= {2'b01, {(SW-2){1'b0}}};
            end
            kssc_pkg::CMD_RSTEP:
            begin
                if (n_reg >= r_trial)
                begin
                    n_reg    <= n_reg - r_trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                    root_reg <= root_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            kssc_pkg::CMD_DINIT:
            begin
                // high part is below speed since the quotient fits W bits
                rem_reg <= div_hi[W:0];
                lo_reg  <= prod_reg[W-1:0];
            end
            kssc_pkg::CMD_DSTEP:
            begin
                rem_reg <= d_ge ? d_rem2 - {1'b0, speed} : d_rem2;
                lo_reg  <= {lo_reg[W-2:0], d_ge};
            end
            default: ;
        endcase
    end

    assign pos     = pos_reg;
    assign vel     = vel_reg;
    assign clamped = clamped_reg;
endmodule
